// ===== sv/page_table_walk_translate_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Page-table walker assertion macros
// Property shorthands for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef PAGE_TABLE_WALK_TRANSLATE_UNIT_ASSERT_SVH
`define PAGE_TABLE_WALK_TRANSLATE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page table walker check failed");

// Next-cycle implication, checked outside reset.
`define PTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page table walker check failed");

`endif

// ===== sv/ptw_pkg.sv =====
// ---------------------------------------------------------------------------
// Page-table walker package
// Item types, codes and the command/status bundles between the controller
// and the datapath.
// ---------------------------------------------------------------------------
package ptw_pkg;

  localparam int PA_W = 52;
  localparam int VA_W = 64;

  // Input op codes
  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_UNMAP     = 2'd1;
  localparam logic [1:0] OP_MEM_DATA  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Page size codes
  localparam logic [1:0] SIZE_NONE = 2'd0;
  localparam logic [1:0] SIZE_4K   = 2'd1;
  localparam logic [1:0] SIZE_2M   = 2'd2;
  localparam logic [1:0] SIZE_1G   = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BUSY   = 2'd1;
  localparam logic [1:0] STATUS_NOROOT = 2'd2;

  // Entry address source
  localparam logic [1:0] ADDR_NONE  = 2'd0;
  localparam logic [1:0] ADDR_ROOT  = 2'd1;
  localparam logic [1:0] ADDR_CUR   = 2'd2;
  localparam logic [1:0] ADDR_ENTRY = 2'd3;

  // Table level used to pick the index bits of the virtual address
  localparam logic [1:0] LVL_4 = 2'd0;
  localparam logic [1:0] LVL_3 = 2'd1;
  localparam logic [1:0] LVL_2 = 2'd2;
  localparam logic [1:0] LVL_1 = 2'd3;

  // Physical address source
  localparam logic [1:0] PHYS_ZERO = 2'd0;
  localparam logic [1:0] PHYS_1G   = 2'd1;
  localparam logic [1:0] PHYS_2M   = 2'd2;
  localparam logic [1:0] PHYS_4K   = 2'd3;

  // Entry bits
  localparam int BIT_PRESENT = 0;
  localparam int BIT_HUGE    = 7;

  typedef struct packed {
    logic [1:0]      op;
    logic [VA_W-1:0] vaddr;
    logic [63:0]     entry_data;
  } ptw_item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [PA_W-1:0] mem_addr;
    logic [PA_W-1:0] xlat_addr;
    logic [1:0]      size_code;
    logic [1:0]      status;
  } ptw_result_t;

  typedef struct packed {
    logic       result_en;
    logic [1:0] kind;
    logic [1:0] size_code;
    logic [1:0] status;
    logic [1:0] addr_src;
    logic [1:0] addr_lvl;
    logic [1:0] phys_src;
    logic       load_req;
    logic       load_base;
  } ptw_cmd_t;

  typedef struct packed {
    logic root_zero;
    logic present;
    logic huge;
    logic frame_zero;
  } ptw_stat_t;

endpackage

// ===== sv/page_table_walk_translate_unit.sv =====
// ---------------------------------------------------------------------------
// Page-table walk and translate unit
// Four-level x86-64 walker that reaches memory through its own items.
// ---------------------------------------------------------------------------
// Every item is taken when offered and its result, if any, is shown on
// result for exactly one cycle, with result_strobe high, on the cycle after
// the item is taken; busy stays low, so a new item may follow every cycle.
// The receiver cannot stall: latch each result on the strobe. A translate
// or unmap item starts a walk (root set) and answers with a read of the
// level 4 entry; feed each entry back as a memory data item, and the walk
// answers with the next read, a write-zero of the leaf entry (unmap) or a
// done result. A request mid-walk is answered done with busy status and
// leaves the walk alone. Write root_table_addr only while no walk runs.
// ---------------------------------------------------------------------------
module page_table_walk_translate_unit
  import ptw_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ptw_item_t       item,
  output logic            result_strobe,
  output ptw_result_t     result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [PA_W-1:0] cfg_data
);

`include "page_table_walk_translate_unit_assert.svh"

  ptw_cmd_t  cmd;
  ptw_stat_t stat;
  logic      accept;

  // Nothing to stall on: never hold off an item or a register write
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  ptw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .op     (item.op),
    .stat   (stat),
    .cmd    (cmd)
  );

  ptw_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .item          (item),
    .cmd           (cmd),
    .stat          (stat),
    .result        (result),
    .result_strobe (result_strobe)
  );

  // No result appears without an item taken the cycle before
  `PTW_ASSERT_NEXT(a_no_spurious_result, !accept, !result_strobe)
  // Read requests carry no translation
  `PTW_ASSERT_IMPL(a_read_clean, result_strobe && result.kind == KIND_READ,
    result.xlat_addr == '0 && result.size_code == SIZE_NONE && result.status == STATUS_OK)
  // A write-zero always names a page size and an 8-byte aligned entry
  `PTW_ASSERT_IMPL(a_write_sized, result_strobe && result.kind == KIND_WRITE,
    result.size_code != SIZE_NONE && result.mem_addr[2:0] == 3'd0)

endmodule

// ===== sv/ptw_ctrl.sv =====
// ---------------------------------------------------------------------------
// Page-table walker controller
// Walk phase state machine; decodes each item into a datapath command.
// ---------------------------------------------------------------------------
module ptw_ctrl
  import ptw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic [1:0] op,
  input  ptw_stat_t stat,
  output ptw_cmd_t  cmd
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_L4   = 3'd1;
  localparam logic [2:0] PH_L3   = 3'd2;
  localparam logic [2:0] PH_L2   = 3'd3;
  localparam logic [2:0] PH_L1   = 3'd4;

  logic [2:0] phase, phase_next;
  logic       is_unmap, is_unmap_next;
  logic [1:0] pending_size, pending_size_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      is_unmap     <= 1'b0;
      pending_size <= SIZE_NONE;
    end else begin
      phase        <= phase_next;
      is_unmap     <= is_unmap_next;
      pending_size <= pending_size_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    is_unmap_next     = is_unmap;
    pending_size_next = pending_size;
    cmd               = '0;
    cmd.kind          = KIND_DONE;
    cmd.status        = STATUS_OK;
    cmd.addr_src      = ADDR_NONE;
    cmd.phys_src      = PHYS_ZERO;
    if (accept && (op == OP_TRANSLATE || op == OP_UNMAP)) begin
      cmd.result_en = 1'b1;
      if (phase != PH_IDLE) begin
        cmd.status = STATUS_BUSY;
      end else if (stat.root_zero) begin
        cmd.status = STATUS_NOROOT;
      end else begin
        cmd.kind          = KIND_READ;
        cmd.addr_src      = ADDR_ROOT;
        cmd.addr_lvl      = LVL_4;
        cmd.load_req      = 1'b1;
        is_unmap_next     = (op == OP_UNMAP);
        pending_size_next = SIZE_NONE;
        phase_next        = PH_L4;
      end
    end else if (accept && op == OP_MEM_DATA && phase != PH_IDLE) begin
      cmd.result_en = 1'b1;
      phase_next    = PH_IDLE;
      case (phase)
        PH_L4: begin
          if (stat.present && !(!is_unmap && stat.frame_zero)) begin
            cmd.kind      = KIND_READ;
            cmd.addr_src  = ADDR_ENTRY;
            cmd.addr_lvl  = LVL_3;
            cmd.load_base = 1'b1;
            phase_next    = PH_L3;
          end
        end
        PH_L3: begin
          if (stat.present && stat.huge) begin
            cmd.size_code = SIZE_1G;
            if (is_unmap) begin
              cmd.kind     = KIND_WRITE;
              cmd.addr_src = ADDR_CUR;
              cmd.addr_lvl = LVL_3;
            end else begin
              cmd.phys_src = PHYS_1G;
            end
          end else if (stat.present && !(!is_unmap && stat.frame_zero)) begin
            cmd.kind      = KIND_READ;
            cmd.addr_src  = ADDR_ENTRY;
            cmd.addr_lvl  = LVL_2;
            cmd.load_base = 1'b1;
            phase_next    = PH_L2;
          end
        end
        PH_L2: begin
          if (stat.present && stat.huge) begin
            cmd.size_code = SIZE_2M;
            if (is_unmap) begin
              cmd.kind     = KIND_WRITE;
              cmd.addr_src = ADDR_CUR;
              cmd.addr_lvl = LVL_2;
            end else begin
              cmd.phys_src = PHYS_2M;
            end
          end else if (stat.present) begin
            // Present table pointer: size is 4 KB from here on
            pending_size_next = SIZE_4K;
            cmd.size_code     = SIZE_4K;
            if (is_unmap) begin
              cmd.kind     = KIND_WRITE;
              cmd.addr_src = ADDR_ENTRY;
              cmd.addr_lvl = LVL_1;
            end else if (!stat.frame_zero) begin
              cmd.kind      = KIND_READ;
              cmd.size_code = SIZE_NONE;
              cmd.addr_src  = ADDR_ENTRY;
              cmd.addr_lvl  = LVL_1;
              cmd.load_base = 1'b1;
              phase_next    = PH_L1;
            end
          end
        end
        PH_L1: begin
          cmd.size_code = pending_size;
          if (stat.present) begin
            cmd.phys_src = PHYS_4K;
          end
        end
        default: begin
          // Unused phase codes: drop back to idle silently
          cmd.result_en = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/ptw_dpath.sv =====
// ---------------------------------------------------------------------------
// Page-table walker datapath
// Root register, walk context, entry address and physical address build,
// result register.
// ---------------------------------------------------------------------------
module ptw_dpath
  import ptw_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [PA_W-1:0] cfg_data,
  input  ptw_item_t       item,
  input  ptw_cmd_t        cmd,
  output ptw_stat_t       stat,
  output ptw_result_t     result,
  output logic            result_strobe
);

  logic [PA_W-1:0] root_table_addr;
  logic [VA_W-1:0] saved_vaddr;
  logic [PA_W-1:0] cur_base;

  logic [PA_W-1:0] entry_frame;
  logic [VA_W-1:0] vsel;
  logic [PA_W-1:0] base_sel;
  logic [8:0]      idx;
  logic [PA_W-1:0] slot_addr;
  logic [PA_W-1:0] offset;
  logic [PA_W-1:0] phys_sum;

  assign entry_frame     = {item.entry_data[PA_W-1:12], 12'd0};
  assign stat.root_zero  = (root_table_addr == '0);
  assign stat.present    = item.entry_data[BIT_PRESENT];
  assign stat.huge       = item.entry_data[BIT_HUGE];
  assign stat.frame_zero = (item.entry_data[PA_W-1:12] == '0);

  assign vsel = cmd.load_req ? item.vaddr : saved_vaddr;

  always_comb begin
    case (cmd.addr_src)
      ADDR_ROOT:  base_sel = {root_table_addr[PA_W-1:12], 12'd0};
      ADDR_CUR:   base_sel = cur_base;
      ADDR_ENTRY: base_sel = entry_frame;
      default:    base_sel = '0;
    endcase
    case (cmd.addr_lvl)
      LVL_4:   idx = vsel[47:39];
      LVL_3:   idx = vsel[38:30];
      LVL_2:   idx = vsel[29:21];
      default: idx = vsel[20:12];
    endcase
    case (cmd.phys_src)
      PHYS_1G: offset = {{(PA_W-30){1'b0}}, vsel[29:0]};
      PHYS_2M: offset = {{(PA_W-21){1'b0}}, vsel[20:0]};
      PHYS_4K: offset = {{(PA_W-12){1'b0}}, vsel[11:0]};
      default: offset = '0;
    endcase
  end

  assign slot_addr = (cmd.addr_src == ADDR_NONE) ? '0
                   : base_sel + {{(PA_W-12){1'b0}}, idx, 3'd0};
  assign phys_sum  = (cmd.phys_src == PHYS_ZERO) ? '0 : entry_frame + offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_addr <= '0;
      saved_vaddr     <= '0;
      cur_base        <= '0;
      result_strobe   <= 1'b0;
    end else begin
      result_strobe <= cmd.result_en;
      if (cfg_we) begin
        root_table_addr <= cfg_data;
      end
      if (cmd.load_req) begin
        saved_vaddr <= item.vaddr;
        cur_base    <= {root_table_addr[PA_W-1:12], 12'd0};
      end else if (cmd.load_base) begin
        cur_base <= entry_frame;
      end
    end
  end

  // Result payload needs no reset; the strobe qualifies it
  always_ff @(posedge clk) begin
    if (cmd.result_en) begin
      result.kind      <= cmd.kind;
      result.mem_addr  <= slot_addr;
      result.xlat_addr <= phys_sum;
      result.size_code <= cmd.size_code;
      result.status    <= cmd.status;
    end
  end

endmodule

// ===== test/ptw_walk_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Page-table walk checker
// Watches the item, result and root-table channels of the walker, keeps its
// own copy of the walk state, works out the result each taken item must
// cause and compares every result field by field with the oldest one due.
// ---------------------------------------------------------------------------
module ptw_walk_checker
  import ptw_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  ptw_item_t       item,
  input  logic            result_strobe,
  input  ptw_result_t     result,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [PA_W-1:0] cfg_data,
  output int              mismatches,
  output int              pending,
  output int              results_checked,
  output bit              walk_active
);

  typedef enum logic [2:0] {WALK_IDLE, WAIT_L4, WAIT_L3, WAIT_L2, WAIT_L1} walk_phase_t;

  localparam int SHIFT_L4 = 39;
  localparam int SHIFT_L3 = 30;
  localparam int SHIFT_L2 = 21;
  localparam int SHIFT_L1 = 12;

  walk_phase_t     phase;
  logic [PA_W-1:0] root_base;
  logic            unmap_walk;
  logic [VA_W-1:0] walk_va;
  logic [PA_W-1:0] table_base;
  logic [1:0]      size_seen;
  ptw_result_t     awaited_results[$];

  function automatic logic [PA_W-1:0] frame_of(logic [63:0] e);
    return {e[PA_W-1:12], 12'h000};
  endfunction

  // Entry address: table frame plus eight times the nine index bits.
  function automatic logic [PA_W-1:0] slot_of(logic [PA_W-1:0] base, logic [VA_W-1:0] va,
                                              int shift);
    logic [8:0] idx;
    idx = va[shift +: 9];
    return {base[PA_W-1:12], 12'h000} + {{(PA_W-12){1'b0}}, idx, 3'b000};
  endfunction

  function automatic ptw_result_t result_of(logic [1:0] kind, logic [PA_W-1:0] mem,
                                            logic [PA_W-1:0] phys, logic [1:0] size,
                                            logic [1:0] status);
    ptw_result_t r;
    r.kind      = kind;
    r.mem_addr  = mem;
    r.xlat_addr = phys;
    r.size_code = size;
    r.status    = status;
    return r;
  endfunction

  function automatic ptw_result_t finish_walk(logic [PA_W-1:0] phys, logic [1:0] size);
    phase = WALK_IDLE;
    return result_of(KIND_DONE, '0, phys, size, STATUS_OK);
  endfunction

  function automatic ptw_result_t clear_leaf(logic [PA_W-1:0] mem, logic [1:0] size);
    phase = WALK_IDLE;
    return result_of(KIND_WRITE, mem, '0, size, STATUS_OK);
  endfunction

  function automatic ptw_result_t descend(logic [63:0] e, walk_phase_t nxt, int shift);
    table_base = frame_of(e);
    phase      = nxt;
    return result_of(KIND_READ, slot_of(table_base, walk_va, shift), '0, SIZE_NONE, STATUS_OK);
  endfunction

  // Advance the walk by one taken item; return 1 when it causes a result.
  function automatic bit predict_step(input ptw_item_t it, output ptw_result_t res);
    logic [63:0]     e;
    logic            present;
    logic            huge;
    logic            zero_frame;
    logic [PA_W-1:0] fr;
    e          = it.entry_data;
    present    = e[BIT_PRESENT];
    huge       = e[BIT_HUGE];
    fr         = frame_of(e);
    zero_frame = (fr == '0);
    res        = '0;
    if (it.op == OP_TRANSLATE || it.op == OP_UNMAP) begin
      if (phase != WALK_IDLE) begin
        res = result_of(KIND_DONE, '0, '0, SIZE_NONE, STATUS_BUSY);
      end else if (root_base == '0) begin
        res = result_of(KIND_DONE, '0, '0, SIZE_NONE, STATUS_NOROOT);
      end else begin
        walk_va    = it.vaddr;
        unmap_walk = (it.op == OP_UNMAP);
        size_seen  = SIZE_NONE;
        res        = descend({{(64-PA_W){1'b0}}, root_base}, WAIT_L4, SHIFT_L4);
      end
      return 1'b1;
    end
    if (it.op != OP_MEM_DATA || phase == WALK_IDLE) return 1'b0;
    case (phase)
      WAIT_L4: begin
        if (!present || (!unmap_walk && zero_frame)) res = finish_walk('0, SIZE_NONE);
        else res = descend(e, WAIT_L3, SHIFT_L3);
      end
      WAIT_L3: begin
        if (!present) res = finish_walk('0, SIZE_NONE);
        else if (huge && unmap_walk) res = clear_leaf(slot_of(table_base, walk_va, SHIFT_L3), SIZE_1G);
        else if (huge) res = finish_walk(fr + {{(PA_W-30){1'b0}}, walk_va[29:0]}, SIZE_1G);
        else if (!unmap_walk && zero_frame) res = finish_walk('0, SIZE_NONE);
        else res = descend(e, WAIT_L2, SHIFT_L2);
      end
      WAIT_L2: begin
        if (!present) begin
          res = finish_walk('0, SIZE_NONE);
        end else if (huge && unmap_walk) begin
          res = clear_leaf(slot_of(table_base, walk_va, SHIFT_L2), SIZE_2M);
        end else if (huge) begin
          res = finish_walk(fr + {{(PA_W-21){1'b0}}, walk_va[20:0]}, SIZE_2M);
        end else begin
          // a table pointer here already fixes the size at 4 KB
          size_seen = SIZE_4K;
          if (unmap_walk) res = clear_leaf(slot_of(fr, walk_va, SHIFT_L1), SIZE_4K);
          else if (zero_frame) res = finish_walk('0, SIZE_4K);
          else res = descend(e, WAIT_L1, SHIFT_L1);
        end
      end
      default: begin
        res = finish_walk(present ? fr + {{(PA_W-12){1'b0}}, walk_va[11:0]} : '0, size_seen);
      end
    endcase
    return 1'b1;
  endfunction

  function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    ptw_result_t want;
    ptw_result_t next_res;
    if (rst) begin
      phase      = WALK_IDLE;
      root_base  = '0;
      unmap_walk = 1'b0;
      walk_va    = '0;
      table_base = '0;
      size_seen  = SIZE_NONE;
      awaited_results.delete();
    end else begin
      // compare first: a result always belongs to an item taken earlier
      if (result_strobe) begin
        if (awaited_results.size() == 0) begin
          $error("result with none awaited: kind %0d mem 0x%0h xlat 0x%0h",
                 result.kind, result.mem_addr, result.xlat_addr);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          mismatches += field_differs("kind", want.kind, result.kind)
                      + field_differs("mem_addr", want.mem_addr, result.mem_addr)
                      + field_differs("xlat_addr", want.xlat_addr, result.xlat_addr)
                      + field_differs("size_code", want.size_code, result.size_code)
                      + field_differs("status", want.status, result.status);
          results_checked++;
        end
      end
      if (cfg_valid && cfg_ready) root_base = cfg_data;
      if (start && !busy && predict_step(item, next_res)) awaited_results.push_back(next_res);
    end
    pending     = awaited_results.size();
    walk_active = (phase != WALK_IDLE);
  end

endmodule

// ===== test/tb_page_table_walk_translate_unit.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Page-table walk and translate unit testbench
// Plays the memory side of the walker: issues translate and unmap requests,
// returns table entries as memory data items, and sweeps the root-table
// register across several settings; the checker beside the block does the
// prediction and the comparison.
// ---------------------------------------------------------------------------
module tb_page_table_walk_translate_unit;
  import ptw_pkg::*;

  // Op code the block must ignore in every phase
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;

  logic            clk = 1'b0;
  logic            rst;
  logic            start;
  logic            busy;
  ptw_item_t       item;
  logic            result_strobe;
  ptw_result_t     result;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [PA_W-1:0] cfg_data;

  int              mismatches;
  int              pending;
  int              results_checked;
  bit              walk_active;

  int unsigned     cycle_count;
  int              items_sent;
  int              walks_run;
  bit              idle_on;

  page_table_walk_translate_unit dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  ptw_walk_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .item            (item),
    .result_strobe   (result_strobe),
    .result          (result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .walk_active     (walk_active)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run: count every cycle and give up well past the slowest pass.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Build a table entry from its present bit, huge bit and frame.
  function automatic logic [63:0] pte(bit present, bit huge, logic [PA_W-1:0] frame);
    logic [63:0] e;
    e              = '0;
    e[PA_W-1:12]   = frame[PA_W-1:12];
    e[BIT_PRESENT] = present;
    e[BIT_HUGE]    = huge;
    return e;
  endfunction

  // Random entry: mostly present so that walks go deep, huge now and then,
  // and the odd all-zero or all-ones frame for the zero-pointer and wrap cases.
  function automatic logic [63:0] make_entry();
    logic [63:0] e;
    int          pick;
    e              = rand64();
    e[BIT_PRESENT] = ($urandom_range(0, 99) < 88);
    e[BIT_HUGE]    = ($urandom_range(0, 99) < 20);
    pick           = $urandom_range(0, 19);
    if (pick == 0) e[PA_W-1:12] = '0;
    else if (pick == 1) e[PA_W-1:12] = '1;
    return e;
  endfunction

  // Offer one item at the falling edge and hold it until the block takes it.
  // Leave start high on return: the caller either drives the next item in the
  // same step or lowers start before letting time pass.
  task automatic send(input logic [1:0] op, input logic [VA_W-1:0] va, input logic [63:0] e);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           = 1'b1;
    item.op         = op;
    item.vaddr      = va;
    item.entry_data = e;
    do @(posedge clk); while (busy);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop start and wait until every result due has arrived, then allow for
  // an item still in flight that causes none.
  task automatic settle();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the root-table register, only ever with the walker idle.
  task automatic write_root(input logic [PA_W-1:0] value);
    settle();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One walk: a request, then entries for as long as the walk asks for them,
  // with the occasional rejected request or unused op mixed in mid-walk.
  task automatic run_walk();
    logic [VA_W-1:0] va;
    int              pick;
    idle_on = ($urandom_range(0, 3) != 0);
    pick    = $urandom_range(0, 9);
    va      = rand64();
    if (pick == 0) va = '0;
    else if (pick == 1) va = '1;
    send(($urandom_range(0, 2) == 0) ? OP_UNMAP : OP_TRANSLATE, va, rand64());
    while (walk_active) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) send(($urandom_range(0, 1) == 0) ? OP_UNMAP : OP_TRANSLATE, rand64(), rand64());
      else if (pick == 1) send(OP_UNUSED, rand64(), rand64());
      send(OP_MEM_DATA, rand64(), make_entry());
    end
    // stray memory data or an unused op while idle: both must be ignored
    pick = $urandom_range(0, 9);
    if (pick == 0) send(OP_MEM_DATA, rand64(), make_entry());
    else if (pick == 1) send(OP_UNUSED, rand64(), rand64());
    walks_run++;
  endtask

  initial begin
    logic [PA_W-1:0] root;
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // No root table yet: a request is answered at once, idle data and the
    // unused op cause nothing.
    send(OP_TRANSLATE, '1, rand64());
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, '1));
    send(OP_UNUSED, rand64(), rand64());

    // All-ones root: its low twelve bits must not reach the entry address.
    write_root('1);

    // Full four-level translate with all-ones frames, and a request mid-walk
    // that must be turned away without disturbing the walk.
    send(OP_TRANSLATE, '1, rand64());
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, '1));
    send(OP_UNMAP, rand64(), rand64());
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, '1));
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, '1));
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, '1));

    // 1 GB page whose frame plus offset wraps past 52 bits
    send(OP_TRANSLATE, '1, rand64());
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, 52'h0_0000_0012_3000));
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b1, '1));

    // Unmap of a 2 MB page: clear the level 2 entry
    send(OP_UNMAP, rand64(), rand64());
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, 52'h0_0000_0004_5000));
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, 52'h0_0000_0006_7000));
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b1, 52'h0_0000_0020_0000));

    // Unmap walks on through a zero table pointer, then clears a 1 GB entry
    send(OP_UNMAP, rand64(), rand64());
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, '0));
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b1, 52'h0_0000_4000_0000));

    // Translate hits a zero table pointer at level 2: unmapped, size 4 KB
    send(OP_TRANSLATE, rand64(), rand64());
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, 52'h0_0000_0001_0000));
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, 52'h0_0000_0002_0000));
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, '0));

    // Unmap of a 4 KB page: the level 1 entry is cleared without a read
    send(OP_UNMAP, rand64(), rand64());
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, 52'h0_0000_0003_0000));
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, 52'h0_0000_0005_0000));
    send(OP_MEM_DATA, rand64(), pte(1'b1, 1'b0, 52'h0_0000_0007_0000));

    // Random walks under a sweep of root settings, the extremes among them.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: root = PA_W'(rand64()) & 52'hF_FFFF_FFFF_F000;
        1: root = '0;
        2: root = '1;
        3: root = 52'h0_0000_0000_1000;
        4: root = PA_W'(rand64());
        default: root = PA_W'(rand64()) & 52'hF_FFFF_FFFF_F000;
      endcase
      write_root(root);
      repeat ((root == '0) ? 10 : 36) begin
        run_walk();
        // hold off now and then until every result is in
        if ($urandom_range(0, 15) == 0) settle();
      end
    end

    settle();
    $display("Run covered %0d items over %0d walks and %0d checked results,", items_sent,
             walks_run, results_checked);
    $display("with the root table at zero, all ones, the lowest frame and random values.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
